### rtl/bedd_pkg.sv
// Package with the shared constants, types and root table of the disk density unit.
package bedd_pkg;

  // Default number of fraction bits of the Q8.24 quantities.
  localparam int FracBitsDef = 24;

  // Fixed-point constants of the exponential and logarithm units.
  localparam logic [61:0] TERM_CAP  = 62'h2000_0000_0000_0000;
  localparam logic [38:0] EXP_CLIP  = 39'h40_0000_0000;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0] TWO_Q30   = 32'h8000_0000;
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] MASK32    = 32'hFFFF_FFFF;

  // Register reset values.
  localparam logic [31:0] RATE_ONE_RST = 32'h0100_0000;
  localparam logic [31:0] ZERO_RST     = 32'h0000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_INNER = 3'd0,
    REG_SLOPE = 3'd1,
    REG_BREAK = 3'd2,
    REG_BETA  = 3'd3,
    REG_AXIAL = 3'd4,
    REG_RHO0  = 3'd5
  } reg_idx_e;

  // Stage control handed to the arithmetic units.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  typedef logic [31:0] roots_t [31];

  // Floor square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Successive square roots of two in Q.30, starting from 2.0.
  function automatic roots_t build_roots();
    roots_t t;
    t[0] = TWO_Q30;
    for (int i = 1; i <= 30; i++) begin
      t[i] = 32'(isqrt64(64'(t[i-1]) << 30));
    end
    return t;
  endfunction

  localparam roots_t ROOTS = build_roots();

endpackage

### rtl/bedd_exp2.sv
// Pipelined exponential unit: scales by log2(e), splits, and builds 2^f by root products.
module bedd_exp2 #(
  parameter int MAG_W  = 62,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bedd_pkg::pipe_ctl_t  ctl_i,
  input  logic                 neg_i,
  input  logic [MAG_W-1:0]     mag_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [30:0]          mant_o,
  output logic signed [7:0]    k_o,
  output logic [SIDE_W-1:0]    side_o
);
  import bedd_pkg::*;

  localparam int Steps = 30;

  logic [38:0]       clip;
  logic              v0_q, v1_q;
  logic [55:0]       p1_q;
  logic [48:0]       p0_q;
  logic              neg0_q, neg1_q;
  logic [SIDE_W-1:0] side0_q, side1_q;
  logic [40:0]       ym1_q;
  logic [8:0]        ip;
  logic [31:0]       fr_in;
  logic [31:0]       fr_split;
  logic signed [7:0] k_split;

  logic              v_q    [Steps+1];
  logic [30:0]       m_q    [Steps+1];
  logic [31:0]       fr_q   [Steps+1];
  logic signed [7:0] k_q    [Steps+1];
  logic [SIDE_W-1:0] side_q [Steps+1];

  // Clip the magnitude to the largest useful exponent.
  assign clip = (MAG_W'(EXP_CLIP) < mag_i) ? EXP_CLIP : 39'(mag_i);

  // Two partial products with log2(e).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (ctl_i.en) begin
      v0_q <= ctl_i.valid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      p1_q    <= 56'(clip[38:16]) * 56'(LOG2E_Q32);
      p0_q    <= 49'(clip[15:0]) * 49'(LOG2E_Q32);
      neg0_q  <= neg_i;
      side0_q <= side_i;
      ym1_q   <= 41'(p1_q >> 16) + 41'(p0_q >> 32);
      neg1_q  <= neg0_q;
      side1_q <= side0_q;
    end
  end

  // Split into integer and fraction; a negative value with a nonzero fraction borrows one from the integer.
  always_comb begin
    ip    = ym1_q[40:32];
    fr_in = ym1_q[31:0];
    if (!neg1_q) begin
      k_split  = 8'(ip);
      fr_split = fr_in;
    end else if (fr_in != '0) begin
      k_split  = 8'(-$signed({1'b0, ip}) - 10'sd1);
      fr_split = 32'(-fr_in);
    end else begin
      k_split  = 8'(-$signed({1'b0, ip}));
      fr_split = fr_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      m_q[0]    <= 31'(ONE_Q30);
      fr_q[0]   <= fr_split;
      k_q[0]    <= k_split;
      side_q[0] <= side1_q;
    end
  end

  // One fraction bit per stage multiplies in its root of two.
  for (genvar i = 1; i <= Steps; i++) begin : g_step
    logic [62:0] prod;
    assign prod = 63'(m_q[i-1]) * 63'(ROOTS[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        m_q[i]    <= fr_q[i-1][32-i] ? 31'(prod >> 30) : m_q[i-1];
        fr_q[i]   <= fr_q[i-1];
        k_q[i]    <= k_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign mant_o  = m_q[Steps];
  assign k_o     = k_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

### rtl/bedd_log2.sv
// Pipelined base-two logarithm of a Q.30 value in [1,2] by repeated squaring.
module bedd_log2 #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bedd_pkg::pipe_ctl_t  ctl_i,
  input  logic [31:0]          val_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [30:0]          log_o,
  output logic [SIDE_W-1:0]    side_o
);
  import bedd_pkg::*;

  localparam int Steps = 30;

  logic              v_q    [Steps+1];
  logic [31:0]       x_q    [Steps+1];
  logic [29:0]       r_q    [Steps+1];
  logic              big_q  [Steps+1];
  logic [SIDE_W-1:0] side_q [Steps+1];

  // Entry: an argument of two or more yields exactly one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      big_q[0]  <= (val_i >= TWO_Q30);
      x_q[0]    <= (val_i >= TWO_Q30) ? ONE_Q30 : val_i;
      r_q[0]    <= '0;
      side_q[0] <= side_i;
    end
  end

  // Each stage squares and takes one result bit.
  for (genvar i = 1; i <= Steps; i++) begin : g_step
    logic [63:0] sq;
    logic [31:0] sq30;
    assign sq   = 64'(x_q[i-1]) * 64'(x_q[i-1]);
    assign sq30 = 32'(sq >> 30);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (sq30 >= TWO_Q30) begin
          x_q[i] <= sq30 >> 1;
          r_q[i] <= r_q[i-1] | (30'd1 << (30 - i));
        end else begin
          x_q[i] <= sq30;
          r_q[i] <= r_q[i-1];
        end
        big_q[i]  <= big_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign log_o   = big_q[Steps] ? 31'(ONE_Q30) : {1'b0, r_q[Steps]};
  assign side_o  = side_q[Steps];

endmodule

### rtl/broken_exp_disk_density_unit.sv
// Top level of the broken-exponential disk density unit.
// Usage:
//   The input channel takes a radius (unsigned Q16.16) and a height (signed Q16.16);
//   a transaction completes on a clock edge with in_valid_i high and in_stall_o low.
//   The output channel returns the density (unsigned Q8.24) and a saturation flag;
//   a transaction completes with out_valid_o high and out_stall_i low.
//   Six configuration registers are written through cfg_valid_i/cfg_ready_o with
//   cfg_index_i and cfg_data_i; write them only while no point is in flight.
//   Indexes beyond the register list are ignored.
// Timing:
//   One point enters per cycle while no result waits under out_stall_i.
//   The pipeline depth is set mostly by the two exponential units (33 stages each, one root
//   product per fraction bit) and the logarithm unit (an entry stage and 30
//   squaring stages).
// Reset:
//   rst_ni clears all stage valid bits and loads the register reset values.
// Stall:
//   While a result waits under out_stall_i, every stage holds and in_stall_o is high;
//   nothing is dropped or repeated.
module broken_exp_disk_density_unit #(
  parameter int FRAC_BITS = bedd_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] radius_i,
  input  logic [31:0] height_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] density_value_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bedd_pkg::*;

  localparam int ScaleSh = FRAC_BITS - 16;
  localparam int UpSh    = 32 - FRAC_BITS;
  localparam int SideW   = 1 + 3 * 62;

  // Configuration registers.
  logic [31:0] inner_q, slope_q, break_q, beta_q, axial_q, rho0_q;

  logic        adv;
  pipe_ctl_t   ctl;

  // Front stages.
  logic        v1_q, v2_q, v3_q;
  logic [31:0] zm1_q, dm1_q, r1_q;
  logic        pos1_q, pos2_q, pos3_q;
  logic [63:0] pa2_q, pb2_q, pt2_q;
  logic [61:0] a3_q, b3_q, t3_q;

  // Softplus stages.
  logic              e1_valid;
  logic [30:0]       e1_mant;
  logic signed [7:0] e1_k;
  logic [SideW-1:0]  e1_side;
  logic [7:0]        sh4;
  logic [30:0]       u4;
  logic              v4_q;
  logic [31:0]       lv4_q;
  logic [SideW-1:0]  side4_q;
  logic              l_valid;
  logic [30:0]       l_log;
  logic [SideW-1:0]  l_side;
  logic              v5_q, v6_q, v7_q, v8_q, v9_q;
  logic [62:0]       lp5_q;
  logic [SideW-1:0]  side5_q;
  logic [62:0]       sp6_q;
  logic [61:0]       a6_q, b6_q, a7_q, b7_q, a8_q, b8_q;
  logic [62:0]       hi7_q;
  logic [63:0]       lo7_q;
  logic [61:0]       p8_q;
  logic [63:0]       p8_d;
  logic              bneg;
  logic [31:0]       bm;
  logic signed [64:0] e9;
  logic              eneg9_q;
  logic [62:0]       em9_q;

  // Final stages.
  logic              e2_valid;
  logic [30:0]       e2_mant;
  logic signed [7:0] e2_k;
  logic              v10_q;
  logic [62:0]       prod10_q;
  logic signed [7:0] k10_q;
  logic signed [8:0] s11;
  logic [7:0]        nsh11;
  logic [63:0]       down11;
  logic [31:0]       val_d;
  logic              sat_d;
  logic              out_valid_q;
  logic [31:0]       density_q;
  logic              sat_q;

  // Rate times length, rescaled to Q.32 and capped.
  function automatic logic [61:0] scale_cap(logic [63:0] p);
    logic [63:0] s;
    s = p >> ScaleSh;
    return (s > 64'(TERM_CAP)) ? TERM_CAP : 62'(s);
  endfunction

  // The whole pipeline moves unless a finished result is held by the receiver.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign ctl        = '{en: adv, valid: v3_q};
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= RATE_ONE_RST;
      slope_q <= RATE_ONE_RST;
      break_q <= ZERO_RST;
      beta_q  <= ZERO_RST;
      axial_q <= RATE_ONE_RST;
      rho0_q  <= RATE_ONE_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_INNER: inner_q <= cfg_data_i;
        REG_SLOPE: slope_q <= cfg_data_i;
        REG_BREAK: break_q <= cfg_data_i;
        REG_BETA:  beta_q  <= cfg_data_i;
        REG_AXIAL: axial_q <= cfg_data_i;
        REG_RHO0:  rho0_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0; v10_q <= 1'b0; out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= e1_valid;
      v5_q <= l_valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
      v10_q <= e2_valid;
      out_valid_q <= v10_q;
    end
  end

  // Magnitudes of height and of the distance from the break radius.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zm1_q  <= height_i[31] ? 32'(-height_i) : height_i;
      pos1_q <= radius_i > break_q;
      dm1_q  <= (radius_i > break_q) ? radius_i - break_q : break_q - radius_i;
      r1_q   <= radius_i;
      pa2_q  <= 64'(zm1_q) * 64'(axial_q);
      pb2_q  <= 64'(r1_q) * 64'(inner_q);
      pt2_q  <= 64'(dm1_q) * 64'(slope_q);
      pos2_q <= pos1_q;
      a3_q   <= scale_cap(pa2_q);
      b3_q   <= scale_cap(pb2_q);
      t3_q   <= scale_cap(pt2_q);
      pos3_q <= pos2_q;
    end
  end

  // exp(-|t|) for the softplus term.
  bedd_exp2 #(
    .MAG_W  (62),
    .SIDE_W (SideW)
  ) u_exp_soft (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .neg_i   (1'b1),
    .mag_i   (t3_q),
    .side_i  ({pos3_q, a3_q, b3_q, t3_q}),
    .valid_o (e1_valid),
    .mant_o  (e1_mant),
    .k_o     (e1_k),
    .side_o  (e1_side)
  );

  // Scale the mantissa down by the negative exponent and add one.
  assign sh4 = 8'(-e1_k);
  assign u4  = (sh4 >= 8'd63) ? '0 : (e1_mant >> sh4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lv4_q   <= ONE_Q30 + 32'(u4);
      side4_q <= e1_side;
    end
  end

  bedd_log2 #(
    .SIDE_W (SideW)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: adv, valid: v4_q}),
    .val_i   (lv4_q),
    .side_i  (side4_q),
    .valid_o (l_valid),
    .log_o   (l_log),
    .side_o  (l_side)
  );

  // Sign and magnitude of beta.
  assign bneg = beta_q[31];
  assign bm   = bneg ? 32'(-beta_q) : beta_q;

  // Capped product of beta and the softplus value.
  always_comb begin
    p8_d = (64'(hi7_q) << UpSh) + (lo7_q >> FRAC_BITS);
    if (64'(hi7_q) > (64'(TERM_CAP) >> UpSh)) begin
      p8_d = 64'(TERM_CAP);
    end else if (p8_d > 64'(TERM_CAP)) begin
      p8_d = 64'(TERM_CAP);
    end
  end

  // Exponent sum of the three terms.
  assign e9 = -$signed(65'(a8_q)) - $signed(65'(b8_q))
            + (bneg ? -$signed(65'(p8_q)) : $signed(65'(p8_q)));

  // ln(1+u), softplus, beta product and exponent sum.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lp5_q   <= 63'(l_log) * 63'(LN2_Q32);
      side5_q <= l_side;
      sp6_q   <= (side5_q[SideW-1] ? 63'(side5_q[61:0]) : '0) + 63'(lp5_q >> 30);
      a6_q    <= side5_q[185:124];
      b6_q    <= side5_q[123:62];
      hi7_q   <= 63'(bm) * 63'(sp6_q[62:32]);
      lo7_q   <= 64'(bm) * 64'(sp6_q[31:0]);
      a7_q    <= a6_q;
      b7_q    <= b6_q;
      p8_q    <= 62'(p8_d);
      a8_q    <= a7_q;
      b8_q    <= b7_q;
      eneg9_q <= e9 < 0;
      em9_q   <= (e9 < 0) ? 63'(-e9) : 63'(e9);
    end
  end

  // exp of the total exponent.
  bedd_exp2 #(
    .MAG_W  (63),
    .SIDE_W (1)
  ) u_exp_main (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: adv, valid: v9_q}),
    .neg_i   (eneg9_q),
    .mag_i   (em9_q),
    .side_i  (1'b0),
    .valid_o (e2_valid),
    .mant_o  (e2_mant),
    .k_o     (e2_k),
    .side_o  ()
  );

  // Scale by rho0 and place the binary point with saturation.
  always_comb begin
    s11    = $signed({k10_q[7], k10_q}) - 9'sd30;
    nsh11  = 8'(-s11);
    down11 = '0;
    val_d  = '0;
    sat_d  = 1'b0;
    if (prod10_q == '0) begin
      val_d = '0;
    end else if (s11 >= 0) begin
      if (s11 >= 9'sd32 || 64'(prod10_q) > (64'(MASK32) >> s11[5:0])) begin
        val_d = MASK32;
        sat_d = 1'b1;
      end else begin
        val_d = 32'(64'(prod10_q) << s11[5:0]);
      end
    end else begin
      down11 = (nsh11 >= 8'd64) ? '0 : (64'(prod10_q) >> nsh11[5:0]);
      if (down11 > 64'(MASK32)) begin
        val_d = MASK32;
        sat_d = 1'b1;
      end else begin
        val_d = 32'(down11);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod10_q  <= 63'(rho0_q) * 63'(e2_mant);
      k10_q     <= e2_k;
      density_q <= val_d;
      sat_q     <= sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign density_value_o = density_q;
  assign saturated_o     = sat_q;

  // A saturated result is always the full-scale value.
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> density_value_o == MASK32)
    else $error("saturated result is not full scale");

  // A zero central density gives zero.
  a_rho0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rho0_q == '0 |-> density_value_o == '0 && !saturated_o)
    else $error("zero central density gave a nonzero result");

  // The input side is only held back by a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

### tb/tb_broken_exp_disk_density_unit.sv
// Self-checking testbench of the broken-exponential disk density unit.
module tb_broken_exp_disk_density_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bedd_pkg::*;

  localparam int          Frac     = 24;
  localparam int          Latency  = 108;
  localparam logic [2:0]  RegSpare = 3'd6;
  localparam logic [2:0]  RegTop   = 3'd7;
  localparam logic [63:0] Cap      = 64'h2000_0000_0000_0000;
  localparam logic [63:0] ClipMag  = 64'h40_0000_0000;
  localparam logic [63:0] QOne     = 64'h4000_0000;
  localparam logic [63:0] QTwo     = 64'h8000_0000;
  localparam logic [63:0] Log2e    = 64'd6196328019;
  localparam logic [63:0] Ln2      = 64'd2977044472;
  localparam logic [63:0] Lo32     = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] density;
    logic        sat;
  } density_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] radius_i;
  logic [31:0] height_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] density_value_o;
  logic        saturated_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [31:0] shadow_regs [6];
  logic [63:0] root_tab [31];
  density_t    density_q [$];
  int          errors;
  bit          noisy;
  int          hold_cycles;

  broken_exp_disk_density_unit i_dut (.*);

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Floor square root.
  function automatic logic [63:0] sqrt_floor(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] rate_times(logic [63:0] x, logic [63:0] rate);
    logic [63:0] p;
    p = (x * rate) >> (Frac - 16);
    return (p > Cap) ? Cap : p;
  endfunction

  function automatic logic [63:0] mul_log2e(logic [63:0] mag);
    logic [63:0] m;
    m = (mag > ClipMag) ? ClipMag : mag;
    return (((m >> 16) * Log2e) >> 16) + (((m & 64'hFFFF) * Log2e) >> 32);
  endfunction

  // Power of two split into a Q.30 mantissa and an integer exponent.
  task automatic pow2_split(input bit neg, input logic [63:0] ym,
                            output logic [63:0] mant, output int k);
    logic [63:0] ip;
    logic [63:0] fr;
    ip = ym >> 32;
    fr = ym & Lo32;
    if (!neg) begin
      k = int'(ip);
    end else begin
      k = -int'(ip);
      if (fr != 0) begin
        k = k - 1;
        fr = (64'd1 << 32) - fr;
      end
    end
    mant = QOne;
    for (int i = 1; i <= 30; i++) begin
      if (fr[32-i]) mant = (mant * root_tab[i]) >> 30;
    end
  endtask

  // Smooth break term: max(t,0) + ln(1 + exp(-|t|)).
  task automatic soft_break(input bit pos, input logic [63:0] tm, output logic [63:0] sp);
    logic [63:0] m;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] lg;
    int          k;
    pow2_split(1'b1, mul_log2e(tm), m, k);
    u = (-k >= 63) ? 64'd0 : (m >> (-k));
    v = QOne + u;
    lg = 0;
    if (v >= QTwo) begin
      lg = QOne;
    end else begin
      for (int i = 1; i <= 30; i++) begin
        v = (v * v) >> 30;
        if (v >= QTwo) begin
          v = v >> 1;
          lg[30-i] = 1'b1;
        end
      end
    end
    sp = (pos ? tm : 64'd0) + ((lg * Ln2) >> 30);
  endtask

  // Expected density for one point under the current register settings.
  task automatic predict_density(input logic [31:0] r, input logic [31:0] z,
                                 output density_t res);
    logic [63:0] zm, a, b, dm, tm, sp, bm, hi, lo, p, em, mant, prod, val;
    logic [63:0] rb;
    longint      e;
    bit          pos, bneg;
    int          k, s;
    zm = z[31] ? ((64'd1 << 32) - z) : {32'd0, z};
    a = rate_times(zm, shadow_regs[REG_AXIAL]);
    b = rate_times(r, shadow_regs[REG_INNER]);
    rb = shadow_regs[REG_BREAK];
    pos = r > rb;
    dm = pos ? r - rb : rb - r;
    tm = rate_times(dm, shadow_regs[REG_SLOPE]);
    soft_break(pos, tm, sp);
    bneg = shadow_regs[REG_BETA][31];
    bm = bneg ? ((64'd1 << 32) - shadow_regs[REG_BETA]) : shadow_regs[REG_BETA];
    hi = bm * (sp >> 32);
    lo = bm * (sp & Lo32);
    if (hi > (Cap >> (32 - Frac))) begin
      p = Cap;
    end else begin
      p = (hi << (32 - Frac)) + (lo >> Frac);
      if (p > Cap) p = Cap;
    end
    e = -longint'(a) - longint'(b) + (bneg ? -longint'(p) : longint'(p));
    em = (e < 0) ? 64'(-e) : 64'(e);
    pow2_split(e < 0, mul_log2e(em), mant, k);
    prod = shadow_regs[REG_RHO0] * mant;
    s = k - 30;
    res.sat = 1'b0;
    if (prod == 0) begin
      val = 0;
    end else if (s >= 0) begin
      if (s >= 32 || prod > (Lo32 >> s)) begin
        val = Lo32;
        res.sat = 1'b1;
      end else begin
        val = prod << s;
      end
    end else begin
      val = (-s >= 64) ? 64'd0 : (prod >> (-s));
      if (val > Lo32) begin
        val = Lo32;
        res.sat = 1'b1;
      end
    end
    res.density = val[31:0];
  endtask

  // Offer one point and wait until the block takes it.
  task automatic send_point(input logic [31:0] r, input logic [31:0] z);
    density_t res;
    if (noisy && $urandom_range(99) < 5) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i <= 1'b1;
    radius_i   <= r;
    height_i   <= z;
    do @(posedge clk_i); while (in_stall_o);
    predict_density(r, z, res);
    density_q.push_back(res);
  endtask

  // Let every point in flight come out before touching the registers.
  task automatic drain;
    in_valid_i <= 1'b0;
    wait (density_q.size() == 0);
    repeat (Latency / 4) @(posedge clk_i);
  endtask

  // One register write; the caller drops valid after the batch.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_RHO0) shadow_regs[idx] = data;
  endtask

  task automatic load_regs(input logic [31:0] inner, input logic [31:0] slope,
                           input logic [31:0] brk, input logic [31:0] beta,
                           input logic [31:0] axial, input logic [31:0] rho0);
    drain();
    write_reg(REG_INNER, inner);
    write_reg(REG_SLOPE, slope);
    write_reg(REG_BREAK, brk);
    write_reg(REG_BETA, beta);
    write_reg(REG_AXIAL, axial);
    write_reg(REG_RHO0, rho0);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly moderate magnitudes so results stay in range, sometimes full width.
  function automatic logic [31:0] pick_len();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h0004_0000);
      default: return $urandom_range(32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'd0;
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  task automatic random_points(input int n);
    logic [31:0] z;
    for (int i = 0; i < n; i++) begin
      z = pick_len();
      if ($urandom_range(1)) z = -z;
      send_point(pick_len(), z);
    end
  endtask

  task automatic test_directed;
    send_point(32'd0, 32'd0);
    send_point(32'hFFFF_FFFF, 32'd0);
    send_point(32'd0, 32'h8000_0000);
    send_point(32'd0, 32'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h0001_0000, 32'h0001_0000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF);
    // Radius exactly at the break, then just either side.
    load_regs(32'h0080_0000, 32'h0400_0000, 32'h0003_0000, 32'h0200_0000,
              32'h0100_0000, 32'h0100_0000);
    send_point(32'h0003_0000, 32'd0);
    send_point(32'h0002_FFFF, 32'd0);
    send_point(32'h0003_0001, 32'd0);
    send_point(32'h0010_0000, 32'h0000_8000);
    // Positive beta with no decay drives the density to saturation.
    load_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'd0);
    send_point(32'h0000_1000, 32'd0);
    send_point(32'd0, 32'd0);
    // Zero central density gives zero whatever the exponent.
    load_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_point(32'hFFFF_FFFF, 32'd0);
    send_point(32'h0000_1000, 32'h8000_0000);
    // Strong negative beta and full rates give underflow.
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h8000_0000);
    send_point(32'd0, 32'd0);
    send_point(32'h0000_0100, 32'hFFFF_FF00);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
  endtask

  // Writes to indexes past the register list must leave the settings alone.
  task automatic test_spare_index;
    load_regs(32'h0100_0000, 32'h0100_0000, 32'h0002_0000, 32'h0080_0000,
              32'h0100_0000, 32'h0100_0000);
    write_reg(RegSpare, $urandom);
    write_reg(RegTop, $urandom);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    random_points(40);
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < 8; ph++) begin
      load_regs(pick_rate(), pick_rate(), pick_len(), $urandom, pick_rate(),
                $urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000));
      random_points(115);
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_no_idle;
    noisy = 1'b0;
    random_points(150);
    drain();
    noisy = 1'b1;
  endtask

  // The receiver holds off long enough for the pipeline to fill up.
  task automatic test_backpressure;
    hold_cycles = 400;
    random_points(230);
  endtask

  // Receiver stall, counted in its own process.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= noisy && ($urandom_range(99) < 10);
      end
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    density_t ex;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (density_q.size() == 0) begin
        $error("unexpected result density=%h saturated=%b", density_value_o, saturated_o);
        errors++;
      end else begin
        ex = density_q.pop_front();
        if (density_value_o !== ex.density) begin
          $error("density_value expected %h actual %h", ex.density, density_value_o);
          errors++;
        end
        if (saturated_o !== ex.sat) begin
          $error("saturated expected %b actual %b", ex.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #4ms;
    $display("tb_broken_exp_disk_density_unit failed");
    $finish;
  end

  initial begin
    errors = 0;
    noisy = 1'b1;
    hold_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    radius_i = '0;
    height_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_INNER;
    cfg_data_i = '0;
    root_tab[0] = QTwo;
    for (int i = 1; i <= 30; i++) root_tab[i] = sqrt_floor(root_tab[i-1] << 30);
    shadow_regs[REG_INNER] = 32'h0100_0000;
    shadow_regs[REG_SLOPE] = 32'h0100_0000;
    shadow_regs[REG_BREAK] = 32'd0;
    shadow_regs[REG_BETA]  = 32'd0;
    shadow_regs[REG_AXIAL] = 32'h0100_0000;
    shadow_regs[REG_RHO0]  = 32'h0100_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_spare_index();
    test_random_settings();
    test_no_idle();
    test_backpressure();

    drain();
    repeat (Latency) @(posedge clk_i);
    if (errors == 0 && density_q.size() == 0) begin
      $display("tb_broken_exp_disk_density_unit passed");
    end else begin
      $display("tb_broken_exp_disk_density_unit failed");
    end
    $finish;
  end

endmodule
